>>> hdl/sha256_pkg.sv
// SHA-256 shared types, constants and a rotate-right helper.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package sha256_pkg;
  localparam int unsigned RoundCnt = 64;

  localparam logic [31:0] RoundK [RoundCnt] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam logic [31:0] InitHash [8] = '{
    32'h6A09E667, 32'hBB67AE85, 32'h3C6EF372, 32'hA54FF53A,
    32'h510E527F, 32'h9B05688C, 32'h1F83D9AB, 32'h5BE0CD19
  };

  localparam logic [7:0] PadByte = 8'h80;

  typedef logic [31:0] word_t;
  typedef word_t hash_t [8];

  // Control from sequencer to the round unit
  typedef struct packed {
    logic start;   // load working vars from hash, schedule from block
    logic step;    // run one round
    logic fold;    // add working vars into hash
    logic init;    // restore initial hash
  } rnd_ctrl_t;

  function automatic word_t rotr(word_t x, int unsigned n);
    return (x >> n) | (x << (32 - n));
  endfunction
endpackage
`default_nettype wire

>>> hdl/sha256_round.sv
// SHA-256 compression unit: one round per cycle, 16-word rolling schedule.
// Depends on sha256_pkg.
`timescale 1ns / 1ps
`default_nettype none
module sha256_round (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  sha256_pkg::rnd_ctrl_t      ctrl_i,
  input  wire logic [5:0]            round_i,
  input  wire logic [16*32-1:0]      block_i,
  output sha256_pkg::word_t          hash_o [8]
);
  import sha256_pkg::*;

  word_t hash_q [8];
  word_t var_q [8];
  word_t w_q [16];
  word_t t1, t2, wnew, s0, s1;

  always_comb begin
    s0   = rotr(w_q[1], 7) ^ rotr(w_q[1], 18) ^ (w_q[1] >> 3);
    s1   = rotr(w_q[14], 17) ^ rotr(w_q[14], 19) ^ (w_q[14] >> 10);
    wnew = s1 + w_q[9] + s0 + w_q[0];
    t1 = var_q[7] + (rotr(var_q[4], 6) ^ rotr(var_q[4], 11) ^ rotr(var_q[4], 25))
       + ((var_q[4] & var_q[5]) ^ (~var_q[4] & var_q[6])) + RoundK[round_i] + w_q[0];
    t2 = (rotr(var_q[0], 2) ^ rotr(var_q[0], 13) ^ rotr(var_q[0], 22))
       + ((var_q[0] & var_q[1]) ^ (var_q[0] & var_q[2]) ^ (var_q[1] & var_q[2]));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 8; i++) hash_q[i] <= InitHash[i];
    end else if (ctrl_i.init) begin
      for (int i = 0; i < 8; i++) hash_q[i] <= InitHash[i];
    end else if (ctrl_i.fold) begin
      for (int i = 0; i < 8; i++) hash_q[i] <= hash_q[i] + var_q[i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.start) begin
      for (int i = 0; i < 8; i++) var_q[i] <= hash_q[i];
      for (int i = 0; i < 16; i++) w_q[i] <= block_i[(15-i)*32 +: 32];
    end else if (ctrl_i.step) begin
      var_q[0] <= t1 + t2;
      var_q[1] <= var_q[0];
      var_q[2] <= var_q[1];
      var_q[3] <= var_q[2];
      var_q[4] <= var_q[3] + t1;
      var_q[5] <= var_q[4];
      var_q[6] <= var_q[5];
      var_q[7] <= var_q[6];
      for (int i = 0; i < 15; i++) w_q[i] <= w_q[i+1];
      w_q[15] <= wnew;
    end
  end

  assign hash_o = hash_q;
endmodule
`default_nettype wire

>>> hdl/sha256_byte_stream_hasher_core.sv
// SHA-256 byte-stream hasher top level. Depends on sha256_pkg, sha256_round.
// Input: a byte that does not fill the block is taken in ST_IDLE; the 64th byte
// starts a compression (one round per cycle in the round unit), during which no
// bytes are accepted. End of message: a padding state, then 1-2 padded compressions,
// then 8 digest transactions, one per cycle when the consumer is ready.
// Reset: asynchronous active low; initial hash, empty block and zero length.
`timescale 1ns / 1ps
`default_nettype none
module sha256_byte_stream_hasher_core (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [7:0]  data_byte_i,
  input  wire logic        byte_valid_i,
  input  wire logic        end_of_message_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [31:0]      digest_word_o,
  output logic [2:0]       word_index_o,
  output logic             last_word_o
);
  import sha256_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE, ST_PAD, ST_START, ST_ROUND, ST_FOLD, ST_OUT
  } state_e;

  state_e      state_q;
  logic [5:0]  pos_q;        // bytes held in the block
  logic [60:0] count_q;      // message length in bytes
  logic [5:0]  round_q;
  logic        final_q;      // current compression carries the length
  logic        need_len_q;   // a padded block still follows
  logic [2:0]  oidx_q;
  logic [511:0] block_q;     // big-endian block, byte 0 at the top
  rnd_ctrl_t   ctrl;
  word_t       hash [8];

  logic        accept;
  logic [5:0]  pos_inc;
  logic [60:0] count_inc;

  assign accept    = in_valid_i && in_ready_o;
  assign in_ready_o = (state_q == ST_IDLE);
  assign pos_inc   = pos_q + 6'd1;
  assign count_inc = count_q + 61'd1;

  always_comb begin
    ctrl       = '0;
    ctrl.start = (state_q == ST_START);
    ctrl.step  = (state_q == ST_ROUND);
    ctrl.fold  = (state_q == ST_FOLD);
    ctrl.init  = (state_q == ST_OUT) && out_ready_i && (oidx_q == 3'd7);
  end

  sha256_round u_round (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (ctrl),
    .round_i (round_q),
    .block_i (block_q),
    .hash_o  (hash)
  );

  // Block storage: byte writes on accept, padding in ST_PAD, length block in ST_FOLD
  always_ff @(posedge clk_i) begin
    if (accept && byte_valid_i) begin
      block_q[(63 - pos_q)*8 +: 8] <= data_byte_i;
    end else if (state_q == ST_PAD) begin
      // pos_q marks the pad byte; everything after is zero
      // length field lands in the last 8 bytes when they are free
      for (int b = 0; b < 64; b++) begin
        if (pos_q >= 6'd56 || b < 56) begin
          if (b == pos_q) block_q[(63-b)*8 +: 8] <= PadByte;
          else if (b > pos_q) block_q[(63-b)*8 +: 8] <= 8'h00;
        end
      end
      if (pos_q < 6'd56) block_q[63:0] <= {count_q, 3'b000};
    end else if (state_q == ST_FOLD && need_len_q) begin
      block_q <= {448'd0, count_q, 3'b000};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      pos_q      <= '0;
      count_q    <= '0;
      round_q    <= '0;
      final_q    <= 1'b0;
      need_len_q <= 1'b0;
      oidx_q     <= '0;
    end else begin
      case (state_q)
        ST_IDLE: begin
          if (accept) begin
            if (byte_valid_i) begin
              pos_q   <= pos_inc;
              count_q <= count_inc;
            end
            // full block compresses first; end handled after it
            if (byte_valid_i && pos_q == 6'd63) begin
              state_q <= ST_START;
              final_q <= 1'b0;
              need_len_q <= end_of_message_i; // pending pad on return
            end else if (end_of_message_i) begin
              state_q <= ST_PAD;
            end
          end
        end
        ST_PAD: begin
          state_q    <= ST_START;
          final_q    <= (pos_q < 6'd56);
          need_len_q <= (pos_q >= 6'd56);
        end
        ST_START: begin
          round_q <= '0;
          state_q <= ST_ROUND;
        end
        ST_ROUND: begin
          round_q <= round_q + 6'd1;
          if (round_q == 6'd63) state_q <= ST_FOLD;
        end
        ST_FOLD: begin
          if (final_q) begin
            state_q <= ST_OUT;
            oidx_q  <= '0;
          end else if (need_len_q && pos_q == 6'd0) begin
            // block filled on the end byte: pad a fresh block
            need_len_q <= 1'b0;
            state_q    <= ST_PAD;
          end else if (need_len_q) begin
            need_len_q <= 1'b0;
            final_q    <= 1'b1;
            state_q    <= ST_START;
          end else begin
            state_q <= ST_IDLE;
          end
        end
        ST_OUT: begin
          if (out_ready_i) begin
            oidx_q <= oidx_q + 3'd1;
            if (oidx_q == 3'd7) begin
              state_q <= ST_IDLE;
              pos_q   <= '0;
              count_q <= '0;
              final_q <= 1'b0;
            end
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign out_valid_o   = (state_q == ST_OUT);
  assign digest_word_o = hash[oidx_q];
  assign word_index_o  = oidx_q;
  assign last_word_o   = (oidx_q == 3'd7);
endmodule
`default_nettype wire
